@@ hw/rtl/jpeg_exif_rating_extractor_assert.svh @@
// Assertion macros used by the checker.
`ifndef JPEG_EXIF_RATING_EXTRACTOR_ASSERT_SVH
`define JPEG_EXIF_RATING_EXTRACTOR_ASSERT_SVH

// Same-cycle implication.
`define JXR_ASSERT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define JXR_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/jxr_pkg.sv @@
`timescale 1ns / 1ps

package jxr_pkg;

  localparam int SKIP_WIDTH = 32;
  localparam logic [31:0] SKIP_MAX = 32'((64'd1 << SKIP_WIDTH) - 64'd1);

  localparam logic [15:0] RATING_TAG_RESET = 16'h4746;

  localparam logic [7:0] MK_PREFIX    = 8'hFF;
  localparam logic [7:0] MK_SOI       = 8'hD8;
  localparam logic [7:0] MK_EOI       = 8'hD9;
  localparam logic [7:0] MK_SOS       = 8'hDA;
  localparam logic [7:0] MK_APP1      = 8'hE1;
  localparam logic [7:0] MK_APP_FIRST = 8'hE0;
  localparam logic [7:0] MK_APP_LAST  = 8'hEF;
  localparam logic [7:0] TIFF_LE      = 8'h49;

  localparam logic [2:0] ST_FOUND   = 3'd0;
  localparam logic [2:0] ST_NOTJPEG = 3'd1;
  localparam logic [2:0] ST_NOEXIF  = 3'd2;
  localparam logic [2:0] ST_ABSENT  = 3'd3;
  localparam logic [2:0] ST_TRUNC   = 3'd4;

  typedef struct packed {
    logic        hit;
    logic [15:0] rating;
    logic [2:0]  status;
  } result_t;

  function automatic logic [7:0] exif_sig(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h45;
      2'd1:    c = 8'h78;
      2'd2:    c = 8'h69;
      default: c = 8'h66;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/jxr_parser.sv @@
`timescale 1ns / 1ps

module jxr_parser
  import jxr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [15:0] tag_cfg,
  output result_t     res
);

  typedef enum logic [3:0] {
    PH_SOI0, PH_SOI1, PH_SCAN, PH_MARK, PH_SEGLEN, PH_APP1LEN, PH_SEGSKIP,
    PH_EXIFHDR, PH_TIFF, PH_IFDSKIP, PH_COUNT, PH_ENTRY, PH_DONE
  } phase_t;

  phase_t                phase, phase_next;
  logic [SKIP_WIDTH-1:0] skip, skip_next, skip_dec;
  logic [3:0]            idx, idx_next, idx_inc;
  logic                  le, le_next;
  logic [15:0]           left, left_next, left_dec;
  logic [31:0]           acc, acc_next, acc_tiff, off_s, off_sat;
  logic [15:0]           tag, tag_next, len, seg, val;
  logic                  mism;

  assign skip_dec = skip - SKIP_WIDTH'(1);
  assign idx_inc  = idx + 4'd1;
  assign left_dec = left - 16'd1;

  always_comb begin
    phase_next = phase;
    skip_next  = skip;
    idx_next   = idx;
    le_next    = le;
    left_next  = left;
    acc_next   = acc;
    tag_next   = tag;
    res        = '{hit: 1'b0, rating: 16'd0, status: ST_FOUND};
    len        = {acc[7:0], data_byte};
    seg        = (len < 16'd2) ? 16'd0 : len - 16'd2;
    val        = le ? {data_byte, acc[7:0]} : {acc[7:0], data_byte};
    mism       = acc[0] | ((idx < 4'd4) && (data_byte != exif_sig(idx[1:0])));
    acc_tiff   = acc;
    if (idx >= 4'd4) begin
      if (le) acc_tiff = acc | ({24'd0, data_byte} << {idx[1:0], 3'b000});
      else    acc_tiff = {acc[23:0], data_byte};
    end
    off_s   = (acc_tiff < 32'd8) ? 32'd0 : acc_tiff - 32'd8;
    off_sat = (off_s > SKIP_MAX) ? SKIP_MAX : off_s;

    unique case (phase) inside
      PH_SOI0: begin
        if (data_byte != MK_PREFIX) begin
          res.hit = 1'b1; res.status = ST_NOTJPEG;
        end else phase_next = PH_SOI1;
      end
      PH_SOI1: begin
        if (data_byte != MK_SOI) begin
          res.hit = 1'b1; res.status = ST_NOTJPEG;
        end else phase_next = PH_SCAN;
      end
      PH_SCAN: begin
        if (data_byte == MK_PREFIX) phase_next = PH_MARK;
      end
      PH_MARK: begin
        if (data_byte == MK_PREFIX) begin
          phase_next = PH_MARK;
        end else if (data_byte == MK_SOS || data_byte == MK_EOI) begin
          res.hit = 1'b1; res.status = ST_NOEXIF;
        end else begin
          idx_next = 4'd0;
          acc_next = 32'd0;
          if (data_byte == MK_APP1) phase_next = PH_APP1LEN;
          else if (data_byte >= MK_APP_FIRST && data_byte <= MK_APP_LAST)
            phase_next = PH_SEGLEN;
          else phase_next = PH_SCAN;
        end
      end
      PH_SEGLEN, PH_APP1LEN: begin
        if (idx == 4'd0) begin
          acc_next = {24'd0, data_byte};
          idx_next = 4'd1;
        end else begin
          skip_next = SKIP_WIDTH'(seg);
          idx_next  = 4'd0;
          acc_next  = 32'd0;
          if (seg == 16'd0) phase_next = PH_SCAN;
          else if (phase == PH_APP1LEN) phase_next = PH_EXIFHDR;
          else phase_next = PH_SEGSKIP;
        end
      end
      PH_SEGSKIP: begin
        skip_next = skip_dec;
        if (skip_dec == '0) phase_next = PH_SCAN;
      end
      PH_EXIFHDR: begin
        skip_next = skip_dec;
        if (idx_inc >= 4'd6) begin
          idx_next = 4'd0;
          acc_next = 32'd0;
          if (!mism) phase_next = PH_TIFF;
          else phase_next = (skip_dec == '0) ? PH_SCAN : PH_SEGSKIP;
        end else if (skip_dec == '0) begin
          idx_next   = 4'd0;
          acc_next   = 32'd0;
          phase_next = PH_SCAN;
        end else begin
          idx_next = idx_inc;
          acc_next = {31'd0, mism};
        end
      end
      PH_TIFF: begin
        if (idx == 4'd0) le_next = (data_byte == TIFF_LE);
        if (idx_inc >= 4'd8) begin
          skip_next  = SKIP_WIDTH'(off_sat);
          idx_next   = 4'd0;
          acc_next   = 32'd0;
          phase_next = (off_sat == 32'd0) ? PH_COUNT : PH_IFDSKIP;
        end else begin
          acc_next = acc_tiff;
          idx_next = idx_inc;
        end
      end
      PH_IFDSKIP: begin
        skip_next = skip_dec;
        if (skip_dec == '0) phase_next = PH_COUNT;
      end
      PH_COUNT: begin
        if (idx == 4'd0) begin
          acc_next = {24'd0, data_byte};
          idx_next = 4'd1;
        end else begin
          left_next = val;
          idx_next  = 4'd0;
          acc_next  = 32'd0;
          if (val == 16'd0) begin
            res.hit = 1'b1; res.status = ST_ABSENT;
          end else phase_next = PH_ENTRY;
        end
      end
      PH_ENTRY: begin
        if (idx == 4'd0) tag_next = {8'd0, data_byte};
        if (idx == 4'd1) tag_next = le ? {data_byte, tag[7:0]} : {tag[7:0], data_byte};
        if (idx == 4'd8) acc_next = {24'd0, data_byte};
        if (idx == 4'd9) acc_next = {16'd0, val};
        if (idx == 4'd9 && tag == tag_cfg) begin
          res.hit    = 1'b1;
          res.status = ST_FOUND;
          res.rating = val;
        end else if (idx_inc >= 4'd12) begin
          idx_next  = 4'd0;
          acc_next  = 32'd0;
          left_next = left_dec;
          if (left_dec == 16'd0) begin
            res.hit = 1'b1; res.status = ST_ABSENT;
          end
        end else begin
          idx_next = idx_inc;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase

    if (res.hit) phase_next = PH_DONE;

    if (last_byte) begin
      if (phase_next != PH_DONE) begin
        res.hit = 1'b1;
        case (phase_next) inside
          PH_SOI0, PH_SOI1: res.status = ST_NOTJPEG;
          PH_SCAN, PH_MARK: res.status = ST_NOEXIF;
          default:          res.status = ST_TRUNC;
        endcase
      end
      phase_next = PH_SOI0;
      skip_next  = '0;
      idx_next   = 4'd0;
      le_next    = 1'b0;
      left_next  = 16'd0;
      acc_next   = 32'd0;
      tag_next   = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SOI0;
      skip  <= '0;
      idx   <= 4'd0;
      le    <= 1'b0;
      left  <= 16'd0;
      acc   <= 32'd0;
      tag   <= 16'd0;
    end else if (step) begin
      phase <= phase_next;
      skip  <= skip_next;
      idx   <= idx_next;
      le    <= le_next;
      left  <= left_next;
      acc   <= acc_next;
      tag   <= tag_next;
    end
  end

endmodule

@@ hw/rtl/jpeg_exif_rating_extractor.sv @@
`timescale 1ns / 1ps
// A byte's result request is registered: the byte goes to the held-byte register, then to result_valid.
// Throughput: one byte per cycle while no result request is stalled; the parse step is one registered stage.
// byte_stall is high during reset and while a result request waits and a byte is held.
// Reset (rst, synchronous) clears parse state and requests; tag_cfg -> 0x4746.

module jpeg_exif_rating_extractor
  import jxr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [15:0] rating,
  output logic [2:0]  status,
  input  logic        rating_tag_we,
  input  logic [15:0] rating_tag
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       held_last;
  logic [15:0] tag_cfg;
  logic       advance, accept, step;
  result_t    res;

  assign advance    = !(result_valid && result_stall);
  assign byte_stall = rst || (held_valid && !advance);
  assign accept     = byte_valid && !byte_stall;
  assign step       = held_valid && advance;

  jxr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (held_byte),
    .last_byte (held_last),
    .tag_cfg   (tag_cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_cfg      <= RATING_TAG_RESET;
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rating_tag_we) tag_cfg <= rating_tag;
      if (accept) held_valid <= 1'b1;
      else if (advance) held_valid <= 1'b0;
      if (advance) result_valid <= step && res.hit;
    end
    if (accept) begin
      held_byte <= data_byte;
      held_last <= last_byte;
    end
    if (step && res.hit && advance) begin
      rating <= res.rating;
      status <= res.status;
    end
  end

endmodule

@@ hw/rtl/jxr_checker.sv @@
`timescale 1ns / 1ps
`include "jpeg_exif_rating_extractor_assert.svh"

module jxr_checker
  import jxr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        byte_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [15:0] rating,
  input logic [2:0]  status
);

  `JXR_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall,
                   result_valid && $stable(rating) && $stable(status),
                   "result request changed while stalled")
  `JXR_ASSERT(a_status_range, clk, rst, result_valid, status <= ST_TRUNC,
              "status code out of range")
  `JXR_ASSERT(a_rating_zero, clk, rst, result_valid && status != ST_FOUND,
              rating == 16'd0, "nonzero rating without a found tag")
  `JXR_ASSERT(a_stall_cause, clk, rst, byte_stall, result_valid && result_stall,
              "byte stall without a waiting result")
  `JXR_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !result_valid,
                   "result request right after reset")

endmodule

bind jpeg_exif_rating_extractor jxr_checker u_checker (.*);
